// ----- design/assert_macros.svh -----
// Assertion macros used by the top level of the row elimination block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on clk, off during reset.
`define BGRE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked on clk, off during reset.
`define BGRE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/bgre_pkg.sv -----
// Package with types and constants of the banded GF(2) row elimination block.
`timescale 1ns / 1ps
`default_nettype none
package bgre_pkg;
    localparam logic [63:0] GOLDEN           = 64'h9e3779b97f4a7c13;
    localparam logic [31:0] FRONT_SKIP       = 32'd64;
    localparam logic [31:0] BAND_WIDTH       = 32'd128;
    localparam logic [31:0] SLOT_COUNT_RESET = 32'd1024;
    localparam int          LIVE_WINDOW_DEF  = 128;
    localparam logic        ADDR_SLOT_COUNT  = 1'b0;
    localparam int          ROW_W            = 128;
    localparam int          ENTRY_W          = 192;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CLAMP,
        ST_MUL,
        ST_MIX,
        ST_RET_RD,
        ST_RET_CHK,
        ST_ELIM,
        ST_TZ,
        ST_STORE,
        ST_OUT
    } bgre_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic clamp;
        logic mul;
        logic mix;
        logic ret_rd;
        logic ret_chk;
        logic elim;
        logic tz;
        logic store;
        logic out_load;
    } bgre_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic live_zero;
        logic ret_hit;
        logic elim_done;
        logic row_zero;
        logic byte_hit;
        logic out_free;
    } bgre_stat_t;
endpackage
`default_nettype wire

// ----- design/bgre_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bgre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- design/bgre_ctrl.sv -----
// Controller state machine that sequences one hash through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module bgre_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bgre_pkg::bgre_stat_t stat,
    output bgre_pkg::bgre_cmd_t      cmd
);
    import bgre_pkg::*;

    bgre_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the phases and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (stat.mul_done)
                begin
                    state_next = ST_MIX;
                end
                else
                begin
                    cmd.mul = 1'b1;
                end
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_RET_RD;
            end
            ST_RET_RD:
            begin
                if (stat.live_zero)
                begin
                    state_next = ST_ELIM;
                end
                else
                begin
                    cmd.ret_rd = 1'b1;
                    state_next = ST_RET_CHK;
                end
            end
            ST_RET_CHK:
            begin
                cmd.ret_chk = 1'b1;
                state_next  = stat.ret_hit ? ST_RET_RD : ST_ELIM;
            end
            ST_ELIM:
            begin
                if (stat.elim_done)
                begin
                    state_next = ST_TZ;
                end
                else
                begin
                    cmd.elim = 1'b1;
                end
            end
            ST_TZ:
            begin
                cmd.tz = 1'b1;
                if (stat.row_zero || stat.byte_hit)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- design/bgre_datapath.sv -----
// Datapath: band start, row hash, live window, elimination and result word.
`timescale 1ns / 1ps
`default_nettype none
module bgre_datapath #(
    parameter int LIVE_WINDOW = bgre_pkg::LIVE_WINDOW_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bgre_pkg::bgre_cmd_t  cmd,
    output bgre_pkg::bgre_stat_t      stat,
    input  wire logic [31:0]          slot_count,
    input  wire logic [63:0]          key_hash,
    input  wire logic                 new_build,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               band_start,
    output logic [31:0]               pivot_column,
    output logic                      row_failed,
    output logic [31:0]               failed_count,
    output logic                      order_error
);
    import bgre_pkg::*;

    localparam int IDX_W = $clog2(LIVE_WINDOW);
    localparam int CNT_W = $clog2(LIVE_WINDOW + 1);
    localparam int SUM_W = IDX_W + 2;

    logic [63:0]      hash_reg;
    logic [64:0]      a_reg;
    logic [63:0]      smul_reg;
    logic [31:0]      start_reg;
    logic [31:0]      prev_reg;
    logic             order_reg;
    logic [2:0]       mul_cnt_reg;
    logic [63:0]      prod_reg;
    logic [1:0]       psh_reg;
    logic [ROW_W-1:0] acc_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CNT_W-1:0] live_reg;
    logic [IDX_W-1:0] oldest_reg;
    logic [CNT_W-1:0] k_reg;
    logic             pend_reg;
    logic [3:0]       tz_reg;
    logic [31:0]      pivot_reg;
    logic             failed_reg;
    logic [31:0]      fail_total_reg;
    logic             out_valid_reg;
    logic [31:0]      out_start_reg;
    logic [31:0]      out_pivot_reg;
    logic             out_failed_reg;
    logic [31:0]      out_count_reg;
    logic             out_order_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_we;

    // Wrap an offset from a base slot around the circular window
    function automatic logic [IDX_W-1:0] slot_at(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {2'b00, base} + SUM_W'(off);
        if (sum >= SUM_W'(LIVE_WINDOW))
        begin
            sum = sum - SUM_W'(LIVE_WINDOW);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Index of the lowest set bit of a nonzero byte
    function automatic logic [2:0] ctz8(logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = 3'(i);
            end
        end
        return n;
    endfunction

    // Band start from the registered multiply-high
    logic [31:0] r_raw, r_skip, bound, start_calc;
    always_comb
    begin
        r_raw      = smul_reg[63:32];
        r_skip     = ((r_raw < FRONT_SKIP) ? FRONT_SKIP : r_raw) - FRONT_SKIP;
        bound      = slot_count - BAND_WIDTH;
        start_calc = ((r_skip > bound) ? bound : r_skip) & ~32'd15;
    end

    // Partial product operands of the row multiply
    logic [31:0] mul_a, mul_g;
    assign mul_a = mul_cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign mul_g = mul_cnt_reg[0] ? GOLDEN[63:32] : GOLDEN[31:0];

    // Row mixing after the multiply
    logic [63:0] mix_lo, mix_hi;
    always_comb
    begin
        mix_hi = acc_reg[127:64] + (a_reg[64] ? GOLDEN : 64'd0);
        mix_lo = acc_reg[63:0] ^ (hash_reg << 17) ^ (hash_reg >> 47);
        mix_hi = mix_hi ^ (hash_reg >> 47) ^ (hash_reg << 17);
        mix_hi[63] = 1'b1;
    end

    // Fields of the live row read back from the store
    logic [ROW_W-1:0] ent_row;
    logic [31:0]      ent_start, ent_pivot, ent_b, ent_d;
    logic             ent_use;
    always_comb
    begin
        ent_row   = ram_rdata[191:64];
        ent_start = ram_rdata[63:32];
        ent_pivot = ram_rdata[31:0];
        ent_b     = ent_pivot - start_reg;
        ent_d     = start_reg - ent_start;
        ent_use   = (ent_start <= start_reg) && (start_reg <= ent_pivot) &&
                    (ent_b < BAND_WIDTH) && (ent_d < BAND_WIDTH) &&
                    row_reg[ent_b[6:0]];
    end

    // Trailing zero scan, one byte a cycle
    logic [7:0] tz_byte;
    assign tz_byte = row_reg[{tz_reg, 3'b000} +: 8];

    logic full;
    assign full = (live_reg == CNT_W'(LIVE_WINDOW));

    // Store port selection
    assign ram_raddr = cmd.ret_rd ? oldest_reg : slot_at(oldest_reg, k_reg);
    assign ram_we    = cmd.store && !failed_reg;
    assign ram_waddr = full ? oldest_reg : slot_at(oldest_reg, live_reg);
    assign ram_wdata = {row_reg, start_reg, pivot_reg};

    bgre_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIVE_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state: window counters, build state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            oldest_reg     <= '0;
            prev_reg       <= '0;
            fail_total_reg <= '0;
            mul_cnt_reg    <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            tz_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load && new_build)
            begin
                live_reg       <= '0;
                oldest_reg     <= '0;
                prev_reg       <= '0;
                fail_total_reg <= '0;
            end
            if (cmd.clamp)
            begin
                prev_reg    <= start_calc;
                mul_cnt_reg <= '0;
            end
            if (cmd.mul)
            begin
                mul_cnt_reg <= mul_cnt_reg + 3'd1;
            end
            if (cmd.mix)
            begin
                k_reg    <= '0;
                pend_reg <= 1'b0;
                tz_reg   <= '0;
            end
            if (cmd.ret_chk && stat.ret_hit)
            begin
                oldest_reg <= slot_at(oldest_reg, CNT_W'(1));
                live_reg   <= live_reg - CNT_W'(1);
            end
            if (cmd.elim)
            begin
                pend_reg <= (k_reg < live_reg);
                if (k_reg < live_reg)
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
            end
            if (cmd.tz && !stat.row_zero && !stat.byte_hit)
            begin
                tz_reg <= tz_reg + 4'd1;
            end
            if (cmd.store)
            begin
                if (failed_reg)
                begin
                    if (fail_total_reg != 32'hFFFF_FFFF)
                    begin
                        fail_total_reg <= fail_total_reg + 32'd1;
                    end
                end
                else if (full)
                begin
                    oldest_reg <= slot_at(oldest_reg, CNT_W'(1));
                end
                else
                begin
                    live_reg <= live_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hash_reg <= key_hash;
        end
        if (cmd.start)
        begin
            smul_reg <= 64'(hash_reg[63:32]) * 64'(slot_count);
            a_reg    <= {1'b0, hash_reg} + {1'b0, GOLDEN};
        end
        if (cmd.clamp)
        begin
            start_reg <= start_calc;
            order_reg <= (start_calc < prev_reg);
            acc_reg   <= '0;
        end
        if (cmd.mul)
        begin
            if (mul_cnt_reg < 3'd4)
            begin
                prod_reg <= 64'(mul_a) * 64'(mul_g);
                psh_reg  <= 2'({1'b0, mul_cnt_reg[1]} + {1'b0, mul_cnt_reg[0]});
            end
            if (mul_cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + ({64'd0, prod_reg} << {psh_reg, 5'b00000});
            end
        end
        if (cmd.mix)
        begin
            row_reg <= {mix_hi, mix_lo};
        end
        if (cmd.elim && pend_reg && ent_use)
        begin
            row_reg <= row_reg ^ (ent_row >> ent_d[6:0]);
        end
        if (cmd.tz)
        begin
            if (stat.row_zero)
            begin
                failed_reg <= 1'b1;
                pivot_reg  <= '0;
            end
            else if (stat.byte_hit)
            begin
                failed_reg <= 1'b0;
                pivot_reg  <= start_reg + 32'({tz_reg, ctz8(tz_byte)});
            end
        end
        if (cmd.out_load)
        begin
            out_start_reg  <= start_reg;
            out_pivot_reg  <= pivot_reg;
            out_failed_reg <= failed_reg;
            out_count_reg  <= fail_total_reg;
            out_order_reg  <= order_reg;
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.mul_done  = (mul_cnt_reg == 3'd5);
        stat.live_zero = (live_reg == '0);
        stat.ret_hit   = (ent_pivot < start_reg);
        stat.elim_done = (k_reg == live_reg) && !pend_reg;
        stat.row_zero  = (row_reg == '0);
        stat.byte_hit  = (tz_byte != 8'd0);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign band_start   = out_start_reg;
    assign pivot_column = out_pivot_reg;
    assign row_failed   = out_failed_reg;
    assign failed_count = out_count_reg;
    assign order_error  = out_order_reg;
endmodule
`default_nettype wire

// ----- design/banded_gf2_row_elimination.sv -----
// Banded GF(2) row elimination: stream top level with configuration port.
//
// Each key hash word yields one result word. An item passes through these
// steps in order:
// - the accept, the band start multiply, the clamp, the row multiply of four
//   partial products, and the mix;
// - retirement of rows from the oldest end of the live window, each with a
//   read and a check, and a final retirement check (none when the window
//   runs empty);
// - elimination against each live row through the single read port of the
//   row store (at most LIVE_WINDOW rows), plus a fill and a drain of the read;
// - the trailing zero scan, one byte at a time over the 16 bytes of the row,
//   ending at the first nonzero byte or at once for a failed row;
// - the store and the output handoff.
// The output handoff stalls while the previous result word still waits
// unaccepted. One hash is handled at a time; the result word waits in an
// output register while the next hash is taken. The row store needs no
// clearing.
`timescale 1ns / 1ps
`default_nettype none
module banded_gf2_row_elimination #(
    parameter int LIVE_WINDOW = bgre_pkg::LIVE_WINDOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] key_hash
    input  wire logic [0:0]  s_tuser,   // [0] new_build
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata,   // [31:0] band_start, [63:32] pivot_column,
                                        // [95:64] failed_count
    output logic      [1:0]  m_tuser    // [0] row_failed, [1] order_error
);
    import bgre_pkg::*;

    `include "assert_macros.svh"

    logic [31:0] slot_count_reg;
    bgre_cmd_t   cmd;
    bgre_stat_t  stat;
    logic        row_failed, order_error;
    logic [31:0] band_start, pivot_column, failed_count;

    // Hold the slot count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_SLOT_COUNT))
        begin
            slot_count_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_SLOT_COUNT) ? slot_count_reg : 32'd0;

    bgre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bgre_datapath #(
        .LIVE_WINDOW (LIVE_WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .slot_count   (slot_count_reg),
        .key_hash     (s_tdata),
        .new_build    (s_tuser[0]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .band_start   (band_start),
        .pivot_column (pivot_column),
        .row_failed   (row_failed),
        .failed_count (failed_count),
        .order_error  (order_error)
    );

    assign m_tdata = {failed_count, pivot_column, band_start};
    assign m_tuser = {order_error, row_failed};

    // One hash in flight: no second word taken right after one is accepted
    `BGRE_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // A failed row reports pivot column zero
    `BGRE_ASSERT_IMP(a_failed_pivot_zero, m_tvalid && m_tuser[0], m_tdata[63:32] == 32'd0)
    // A failure word carries a nonzero failure count
    `BGRE_ASSERT_IMP(a_failed_counted, m_tvalid && m_tuser[0], m_tdata[95:64] != 32'd0)
endmodule
`default_nettype wire
